/* hw/rtl/rhwf_pkg.sv */
`default_nettype none

package rhwf_pkg;

  // Field widths of the request, result and configuration channels
  localparam int GridSizeW = 6;
  localparam int PosW      = 5;
  localparam int HeadW     = 2;
  localparam int KindW     = 2;

  // Request codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  // Cell kinds; bit 0 is the stored wall bit
  localparam logic [KindW-1:0] CELL_OPEN  = 2'd0;
  localparam logic [KindW-1:0] CELL_WALL  = 2'd1;
  localparam logic [KindW-1:0] CELL_START = 2'd2;

  // Headings
  localparam logic [HeadW-1:0] HEAD_UP    = 2'd0;
  localparam logic [HeadW-1:0] HEAD_LEFT  = 2'd1;
  localparam logic [HeadW-1:0] HEAD_DOWN  = 2'd2;
  localparam logic [HeadW-1:0] HEAD_RIGHT = 2'd3;

  // One result transaction
  typedef struct packed {
    logic [PosW-1:0]  pos_row;
    logic [PosW-1:0]  pos_col;
    logic [HeadW-1:0] heading;
    logic             at_exit;
    logic             stuck;
  } res_t;

endpackage

`default_nettype wire

/* hw/rtl/rhwf_cfg_if.sv */
`default_nettype none

interface rhwf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rhwf_pkg::GridSizeW-1:0] grid_size;

  modport source (output valid, output grid_size, input ready);
  modport sink (input valid, input grid_size, output ready);
endinterface

`default_nettype wire

/* hw/rtl/rhwf_req_if.sv */
`default_nettype none

interface rhwf_req_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [rhwf_pkg::KindW-1:0] cell_kind;

  modport source (output valid, output req_type, output cell_kind, input ready);
  modport sink (input valid, input req_type, input cell_kind, output ready);
endinterface

`default_nettype wire

/* hw/rtl/rhwf_res_if.sv */
`default_nettype none

interface rhwf_res_if;
  logic                       valid;
  logic                       ready;
  logic [rhwf_pkg::PosW-1:0]  pos_row;
  logic [rhwf_pkg::PosW-1:0]  pos_col;
  logic [rhwf_pkg::HeadW-1:0] heading;
  logic                       at_exit;
  logic                       stuck;

  modport source (output valid, output pos_row, output pos_col, output heading,
                  output at_exit, output stuck, input ready);
  modport sink (input valid, input pos_row, input pos_col, input heading,
                input at_exit, input stuck, output ready);
endinterface

`default_nettype wire

/* hw/rtl/rhwf_wall_ram.sv */
`default_nettype none

module rhwf_wall_ram #(
  parameter int Depth = 1024
) (
  input  wire                       clk_i,
  input  wire                       we_i,
  input  wire                       re_i,
  input  wire [$clog2(Depth)-1:0]   addr_i,
  input  wire                       wdata_i,
  output logic                      rdata_o
);

  logic mem [Depth];
  logic rdata_q;

  // Single port: write or registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/rhwf_walker.sv */
`default_nettype none

module rhwf_walker #(
  parameter int MaxSide = 32
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  rhwf_req_if.sink                       req_i,
  input  wire                            cfg_wr_i,
  input  wire [$clog2(MaxSide)+1-1:0]    size_i,
  output rhwf_pkg::res_t                 res_o,
  output logic                           res_valid_o,
  input  wire                            res_ready_i
);

  localparam int RowW  = $clog2(MaxSide);
  localparam int CmpW  = RowW + 1;
  localparam int Depth = MaxSide * MaxSide;
  localparam int AddrW = $clog2(Depth);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_LOAD  = 4'b0010,
    ST_PROBE = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [rhwf_pkg::KindW-1:0] kind_q, kind_d;
  logic [RowW-1:0]            row_q, row_d, col_q, col_d;
  logic [RowW-1:0]            ld_row_q, ld_row_d, ld_col_q, ld_col_d;
  logic [rhwf_pkg::HeadW-1:0] head_q, head_d;
  logic                       stuck_q, stuck_d;
  logic [1:0]                 try_q, try_d;
  logic                       iss_done_q, iss_done_d;

  // Probe pipeline: one neighbour in flight through the memory read
  logic                       p_valid_q, p_valid_d;
  logic                       p_ongrid_q, p_ongrid_d;
  logic                       p_last_q, p_last_d;
  logic [rhwf_pkg::HeadW-1:0] p_head_q, p_head_d;
  logic [RowW-1:0]            p_row_q, p_row_d, p_col_q, p_col_d;

  logic [rhwf_pkg::HeadW-1:0] iss_head;
  logic [CmpW-1:0]            rr, cc, nr, nc, size_m1;
  logic                       ongrid;
  logic                       mem_we, mem_re, mem_rdata;
  logic [AddrW-1:0]           mem_addr;
  logic                       probe_open;

  assign size_m1 = size_i - CmpW'(1);

  // Neighbour of the current position in the heading being issued
  assign iss_head = head_q + 2'd3 + try_q;
  assign rr = CmpW'(row_q);
  assign cc = CmpW'(col_q);

  always_comb begin
    nr     = rr;
    nc     = cc;
    ongrid = 1'b1;
    unique case (iss_head)
      rhwf_pkg::HEAD_UP: begin
        ongrid = (rr != '0);
        nr     = rr - CmpW'(1);
      end
      rhwf_pkg::HEAD_LEFT: begin
        ongrid = (cc != '0);
        nc     = cc - CmpW'(1);
      end
      rhwf_pkg::HEAD_DOWN: begin
        nr = rr + CmpW'(1);
      end
      rhwf_pkg::HEAD_RIGHT: begin
        nc = cc + CmpW'(1);
      end
    endcase
    ongrid = ongrid && (nr < size_i) && (nc < size_i);
  end

  // Memory port: load writes, probes read
  always_comb begin
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = AddrW'(nr[RowW-1:0]) * AddrW'(MaxSide) + AddrW'(nc[RowW-1:0]);
    if (state_q == ST_LOAD) begin
      mem_we   = 1'b1;
      mem_addr = AddrW'(ld_row_q) * AddrW'(MaxSide) + AddrW'(ld_col_q);
    end else if (state_q == ST_PROBE && !iss_done_q) begin
      mem_re = ongrid;
    end
  end

  rhwf_wall_ram #(
    .Depth (Depth)
  ) u_wall_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (kind_q[0]),
    .rdata_o (mem_rdata)
  );

  assign probe_open = p_valid_q && p_ongrid_q && !mem_rdata;

  // Sequencer
  always_comb begin
    state_d    = state_q;
    kind_d     = kind_q;
    row_d      = row_q;
    col_d      = col_q;
    ld_row_d   = ld_row_q;
    ld_col_d   = ld_col_q;
    head_d     = head_q;
    stuck_d    = stuck_q;
    try_d      = try_q;
    iss_done_d = iss_done_q;
    p_valid_d  = 1'b0;
    p_ongrid_d = p_ongrid_q;
    p_last_d   = p_last_q;
    p_head_d   = p_head_q;
    p_row_d    = p_row_q;
    p_col_d    = p_col_q;

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          kind_d     = req_i.cell_kind;
          try_d      = '0;
          iss_done_d = 1'b0;
          stuck_d    = 1'b0;
          state_d    = (req_i.req_type == rhwf_pkg::REQ_STEP) ? ST_PROBE : ST_LOAD;
        end
      end
      ST_LOAD: begin
        // Store the wall bit, place the walker on a start cell, advance
        if (kind_q == rhwf_pkg::CELL_START) begin
          row_d = ld_row_q;
          col_d = ld_col_q;
        end
        if (CmpW'(ld_col_q) >= size_m1) begin
          ld_col_d = '0;
          ld_row_d = (CmpW'(ld_row_q) >= size_m1) ? '0 : ld_row_q + RowW'(1);
        end else begin
          ld_col_d = ld_col_q + RowW'(1);
        end
        state_d = ST_EMIT;
      end
      ST_PROBE: begin
        // Issue the next heading
        if (!iss_done_q) begin
          p_valid_d  = 1'b1;
          p_ongrid_d = ongrid;
          p_last_d   = (try_q == 2'd3);
          p_head_d   = iss_head;
          p_row_d    = nr[RowW-1:0];
          p_col_d    = nc[RowW-1:0];
          try_d      = try_q + 2'd1;
          iss_done_d = (try_q == 2'd3);
        end
        // Judge the probe returning from memory
        if (probe_open) begin
          head_d    = p_head_q;
          row_d     = p_row_q;
          col_d     = p_col_q;
          p_valid_d = 1'b0;
          state_d   = ST_EMIT;
        end else if (p_valid_q && p_last_q) begin
          head_d    = p_head_q + 2'd1;
          stuck_d   = 1'b1;
          p_valid_d = 1'b0;
          state_d   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A size write restarts the load sequence
    if (cfg_wr_i) begin
      ld_row_d = '0;
      ld_col_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      row_q      <= '0;
      col_q      <= '0;
      head_q     <= rhwf_pkg::HEAD_UP;
      ld_row_q   <= '0;
      ld_col_q   <= '0;
      stuck_q    <= 1'b0;
      try_q      <= '0;
      iss_done_q <= 1'b0;
      p_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      row_q      <= row_d;
      col_q      <= col_d;
      head_q     <= head_d;
      ld_row_q   <= ld_row_d;
      ld_col_q   <= ld_col_d;
      stuck_q    <= stuck_d;
      try_q      <= try_d;
      iss_done_q <= iss_done_d;
      p_valid_q  <= p_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    p_ongrid_q <= p_ongrid_d;
    p_last_q   <= p_last_d;
    p_head_q   <= p_head_d;
    p_row_q    <= p_row_d;
    p_col_q    <= p_col_d;
  end

  assign req_i.ready = (state_q == ST_IDLE);

  // Result of the finished transaction
  assign res_valid_o     = (state_q == ST_EMIT);
  assign res_o.pos_row   = rhwf_pkg::PosW'(row_q);
  assign res_o.pos_col   = rhwf_pkg::PosW'(col_q);
  assign res_o.heading   = head_q;
  assign res_o.stuck     = stuck_q;
  assign res_o.at_exit   = (rr == '0) || (cc == '0) || (rr >= size_m1) || (cc >= size_m1);

endmodule

`default_nettype wire

/* hw/rtl/right_hand_wall_follower_core.sv */
// A load passes the load and emit states, a step the probe and emit states.
// One request at a time: a new one is taken only in the idle state; a step probes
// up to four neighbours through the single wall memory port, one read per cycle.
// Reset clears the walker to row 0, column 0, heading up, the load position to the
// first cell and the size to 32 (or MaxSide if smaller). The wall memory is not
// cleared and must be loaded before stepping.
`default_nettype none

module right_hand_wall_follower_core #(
  parameter int MaxSide = 32
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  rhwf_cfg_if.sink    cfg_i,
  rhwf_req_if.sink    req_i,
  rhwf_res_if.source  res_o
);

  localparam int SizeW   = $clog2(MaxSide) + 1;
  localparam int SizeRst = (MaxSide < 32) ? MaxSide : 32;

  logic [SizeW-1:0] size_q, size_d;
  logic             cfg_wr;

  rhwf_pkg::res_t   wk_res, out_q;
  logic             wk_valid, slot_free;
  logic             out_valid_q;

  // Clamp the written size to the supported range
  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid;

  always_comb begin
    if (cfg_i.grid_size < rhwf_pkg::GridSizeW'(3)) begin
      size_d = SizeW'(3);
    end else if (int'(cfg_i.grid_size) > MaxSide) begin
      size_d = SizeW'(MaxSide);
    end else begin
      size_d = SizeW'(cfg_i.grid_size);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeW'(SizeRst);
    end else if (cfg_wr) begin
      size_q <= size_d;
    end
  end

  rhwf_walker #(
    .MaxSide (MaxSide)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_wr_i    (cfg_wr),
    .size_i      (size_q),
    .res_o       (wk_res),
    .res_valid_o (wk_valid),
    .res_ready_i (slot_free)
  );

  // Output register: hold the result until the sink takes it
  assign slot_free = !out_valid_q || res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (wk_valid && slot_free) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wk_valid && slot_free) begin
      out_q <= wk_res;
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.pos_row = out_q.pos_row;
  assign res_o.pos_col = out_q.pos_col;
  assign res_o.heading = out_q.heading;
  assign res_o.at_exit = out_q.at_exit;
  assign res_o.stuck   = out_q.stuck;

endmodule

`default_nettype wire

/* tb/right_hand_wall_follower_core_test.sv */
`timescale 1ns / 100ps

module right_hand_wall_follower_core_test;
  import rhwf_pkg::*;

  localparam int MazeSide = 32;
  localparam int HoldCycles = 300;
  // Kind three is not named by the block, but it must be stored as a wall
  localparam logic [KindW-1:0] CellSpareWall = 2'd3;

  typedef enum int {
    TRAFFIC_FREE,
    TRAFFIC_SEND_GAPS,
    TRAFFIC_RECV_STALLS,
    TRAFFIC_BOTH
  } traffic_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int holds_asked = 0;
  int holds_served = 0;

  rhwf_cfg_if cfg_if ();
  rhwf_req_if req_if ();
  rhwf_res_if res_if ();

  right_hand_wall_follower_core #(
    .MaxSide(MazeSide)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .req_i (req_if),
    .res_o (res_if)
  );

  // Tracks the walker and the wall grid, and holds the results still owed
  class walker_scoreboard;
    logic            wall_bit    [MazeSide*MazeSide];
    bit              cell_loaded [MazeSide*MazeSide];
    logic [PosW-1:0] row;
    logic [PosW-1:0] col;
    logic [HeadW-1:0] head;
    int              load_pos;
    logic [GridSizeW-1:0] size_reg;
    res_t            expected_walk[$];
    int              fails;

    function new();
      foreach (cell_loaded[i]) begin
        cell_loaded[i] = 1'b0;
        wall_bit[i] = 1'b0;
      end
      row = '0;
      col = '0;
      head = HEAD_UP;
      load_pos = 0;
      size_reg = 6'd32;
      fails = 0;
    endfunction

    function int grid_side();
      if (size_reg < 3) return 3;
      if (size_reg > MazeSide) return MazeSide;
      return int'(size_reg);
    endfunction

    function int pending();
      return expected_walk.size();
    endfunction

    function void set_grid_size(logic [GridSizeW-1:0] value);
      size_reg = value;
      load_pos = 0;
    endfunction

    // True once every cell of the grid in use has been loaded at least once
    function bit fully_loaded();
      int s;
      s = grid_side();
      for (int r = 0; r < s; r++)
        for (int c = 0; c < s; c++)
          if (!cell_loaded[r*MazeSide+c]) return 1'b0;
      return 1'b1;
    endfunction

    // Off-grid neighbours count as walls
    function bit open_toward(logic [HeadW-1:0] dir, int s);
      int r;
      int c;
      r = row;
      c = col;
      case (dir)
        HEAD_UP: begin
          if (r == 0) return 1'b0;
          r--;
        end
        HEAD_LEFT: begin
          if (c == 0) return 1'b0;
          c--;
        end
        HEAD_DOWN: r++;
        default: c++;
      endcase
      if (r >= s || c >= s) return 1'b0;
      return !wall_bit[r*MazeSide+c];
    endfunction

    // Advance the walker for one accepted request and queue its result
    function void note_request(logic rt, logic [KindW-1:0] kind);
      int s;
      int r;
      int c;
      logic [HeadW-1:0] h;
      bit found;
      res_t e;
      s = grid_side();
      e.stuck = 1'b0;
      if (rt == REQ_LOAD) begin
        if (load_pos >= s*s) load_pos = 0;
        r = load_pos / s;
        c = load_pos % s;
        wall_bit[r*MazeSide+c] = kind[0];
        cell_loaded[r*MazeSide+c] = 1'b1;
        if (kind == CELL_START) begin
          row = r;
          col = c;
        end
        load_pos++;
        if (load_pos >= s*s) load_pos = 0;
      end else begin
        // turn right, then left until the way ahead is open
        h = head + 2'd3;
        found = 1'b0;
        for (int t = 0; t < 4 && !found; t++) begin
          if (open_toward(h, s)) found = 1'b1;
          else h = h + 2'd1;
        end
        head = h;
        if (found) begin
          case (h)
            HEAD_UP:   row = row - 1'b1;
            HEAD_LEFT: col = col - 1'b1;
            HEAD_DOWN: row = row + 1'b1;
            default:   col = col + 1'b1;
          endcase
        end else begin
          e.stuck = 1'b1;
        end
      end
      e.pos_row = row;
      e.pos_col = col;
      e.heading = head;
      e.at_exit = (row == 0 || col == 0 || int'(row) >= s - 1 || int'(col) >= s - 1);
      expected_walk.push_back(e);
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (expected_walk.size() == 0) begin
        $error("result transaction with nothing expected: row %0d col %0d",
               got.pos_row, got.pos_col);
        fails++;
        return;
      end
      e = expected_walk.pop_front();
      if (got.pos_row !== e.pos_row) begin
        $error("pos_row: expected %0d, actual %0d", e.pos_row, got.pos_row);
        fails++;
      end
      if (got.pos_col !== e.pos_col) begin
        $error("pos_col: expected %0d, actual %0d", e.pos_col, got.pos_col);
        fails++;
      end
      if (got.heading !== e.heading) begin
        $error("heading: expected %0d, actual %0d", e.heading, got.heading);
        fails++;
      end
      if (got.at_exit !== e.at_exit) begin
        $error("at_exit: expected %0d, actual %0d", e.at_exit, got.at_exit);
        fails++;
      end
      if (got.stuck !== e.stuck) begin
        $error("stuck: expected %0d, actual %0d", e.stuck, got.stuck);
        fails++;
      end
    endfunction
  endclass

  walker_scoreboard sb;

  // Clock: 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Check every accepted result transaction
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid === 1'b1 && res_if.ready === 1'b1)
      sb.check_result({res_if.pos_row, res_if.pos_col, res_if.heading,
                       res_if.at_exit, res_if.stuck});
  end

  // Drive ready: random stalls, or a long hold-off when one is asked for
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (holds_served != holds_asked) begin
        holds_served++;
        hold_left = HoldCycles;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic set_traffic(input traffic_e mode);
    send_idle_pct = (mode == TRAFFIC_SEND_GAPS) ? 46 : (mode == TRAFFIC_BOTH) ? 25 : 0;
    recv_stall_pct = (mode == TRAFFIC_RECV_STALLS) ? 46 : (mode == TRAFFIC_BOTH) ? 25 : 0;
  endtask

  // Offer one request and hold it until the block accepts it
  task automatic send_request(input logic rt, input logic [KindW-1:0] kind);
    if ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    req_if.valid <= 1'b1;
    req_if.req_type <= rt;
    req_if.cell_kind <= kind;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    sb.note_request(rt, kind);
    @(negedge clk_i);
  endtask

  // Write the size only once the block has drained
  task automatic write_grid_size(input logic [GridSizeW-1:0] value);
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.grid_size <= value;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    sb.set_grid_size(value);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // One maze: resize, optionally load a fresh grid, then mostly steps
  task automatic run_maze(input logic [GridSizeW-1:0] size_val, input traffic_e mode,
                          input bit fresh_load, input int mixed_items, input bit squeeze);
    int cells;
    int start_at;
    int wall_pct;
    int partial;
    logic [KindW-1:0] kind;
    write_grid_size(size_val);
    set_traffic(mode);
    cells = sb.grid_side() * sb.grid_side();
    wall_pct = $urandom_range(45, 15);
    start_at = $urandom_range(cells - 1);
    if (fresh_load) begin
      // now and then break a small load off early
      partial = (cells <= 100 && $urandom_range(9) == 0) ? $urandom_range(cells - 1) : cells;
      for (int i = 0; i < partial; i++) begin
        if (i == start_at) kind = CELL_START;
        else if ($urandom_range(99) < wall_pct)
          kind = ($urandom_range(7) == 0) ? CellSpareWall : CELL_WALL;
        else kind = CELL_OPEN;
        send_request(REQ_LOAD, kind);
      end
    end
    if (squeeze) holds_asked++;
    // steps only over a grid that is wholly loaded; loads fill any gap
    for (int i = 0; i < mixed_items; i++) begin
      if ($urandom_range(99) < 80 && sb.fully_loaded())
        send_request(REQ_STEP, KindW'($urandom_range(3)));
      else
        send_request(REQ_LOAD, KindW'($urandom_range(3)));
    end
  endtask

  initial begin : stimulus
    logic [KindW-1:0] corridor [9];
    logic [KindW-1:0] enclosure [8];
    traffic_e mode;
    logic [GridSizeW-1:0] size_val;
    sb = new();
    cfg_if.valid <= 1'b0;
    cfg_if.grid_size <= '0;
    req_if.valid <= 1'b0;
    req_if.req_type <= REQ_LOAD;
    req_if.cell_kind <= CELL_OPEN;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: a 3x3 grid from a size below the minimum
    corridor = '{CELL_WALL, CELL_OPEN, CellSpareWall,
                 CELL_OPEN, CELL_START, CELL_WALL,
                 CELL_WALL, CELL_OPEN, CELL_WALL};
    enclosure = '{CELL_WALL, CELL_WALL,
                  CELL_WALL, CELL_START, CELL_WALL,
                  CELL_OPEN, CELL_WALL, CELL_OPEN};
    write_grid_size(6'd0);
    set_traffic(TRAFFIC_FREE);
    foreach (corridor[i]) send_request(REQ_LOAD, corridor[i]);
    send_request(REQ_STEP, CELL_OPEN);
    send_request(REQ_STEP, CellSpareWall);
    // load position has wrapped: this start lands on the corner cell
    send_request(REQ_LOAD, CELL_START);
    send_request(REQ_STEP, CELL_WALL);
    // wall in the centre cell on all four sides, then step twice
    foreach (enclosure[i]) send_request(REQ_LOAD, enclosure[i]);
    send_request(REQ_STEP, CELL_OPEN);
    send_request(REQ_STEP, CELL_START);

    // Small mazes, including the sizes that clamp to the minimum
    for (int i = 0; i < 10; i++) begin
      size_val = (i < 3) ? GridSizeW'(i + 1) : GridSizeW'($urandom_range(8, 4));
      mode = traffic_e'(i % 4);
      run_maze(size_val, mode, 1'b1, 40, 1'b0);
    end

    // Full-size grid, then an oversized setting over the same walls
    run_maze(6'd32, TRAFFIC_SEND_GAPS, 1'b1, 120, 1'b0);
    run_maze(6'd63, TRAFFIC_RECV_STALLS, 1'b0, 80, 1'b0);
    // shrink under the walker so it may sit off the grid
    run_maze(6'd5, TRAFFIC_BOTH, 1'b0, 40, 1'b0);
    // hold the receiver off while requests keep coming
    run_maze(6'd7, TRAFFIC_FREE, 1'b1, 80, 1'b1);
    for (int i = 0; i < 3; i++)
      run_maze(GridSizeW'($urandom_range(6, 3)), traffic_e'($urandom_range(3)), 1'b1, 40,
               1'b0);

    // Drain, then allow for any stray result
    req_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin : watchdog
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/rhwf_pkg.sv
hw/rtl/rhwf_cfg_if.sv
hw/rtl/rhwf_req_if.sv
hw/rtl/rhwf_res_if.sv
hw/rtl/rhwf_wall_ram.sv
hw/rtl/rhwf_walker.sv
hw/rtl/right_hand_wall_follower_core.sv
tb/right_hand_wall_follower_core_test.sv
